/* rtl/core/hrl_pkg.sv */
// Shared types and constants of the hex record loader.
// No dependencies.
`default_nettype none

package hrl_pkg;

   localparam int unsigned MEM_DEPTH = 4096;
   localparam logic [16:0] MEM_LIMIT = 17'(MEM_DEPTH);
   localparam logic [7:0]  COLON_CHAR = 8'h3A;

   typedef enum logic [5:0] {
      PH_WAIT = 6'b000001,
      PH_LEN  = 6'b000010,
      PH_ADDR = 6'b000100,
      PH_TYPE = 6'b001000,
      PH_DATA = 6'b010000,
      PH_SUM  = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      RK_WRITE = 3'd0,
      RK_OK    = 3'd1,
      RK_BAD   = 3'd2,
      RK_RANGE = 3'd3,
      RK_CHAR  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  type_code;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/hrl_decode.sv */
// Record parser: field state registers and per-character next-state logic.
// Depends on hrl_pkg.
`default_nettype none

module hrl_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         char_in,
   input  wire logic               step,
   output hrl_pkg::result_type     result,
   output logic                    has_result
);

   hrl_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  digit_ff, digit_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  kind_ff, kind_in;

   logic        hex_ok;
   logic [3:0]  hex_v;
   logic        is_colon;
   logic        start_rec;
   logic [7:0]  byte_val;
   logic [7:0]  byte_sum;
   logic [15:0] addr_shift;
   logic [1:0]  digit_inc;
   logic [16:0] range_sum;

   always_comb begin
      hex_ok = 1'b1;
      hex_v  = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         hex_v = char_in[3:0];
      end else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                   (char_in >= 8'h61 && char_in <= 8'h66)) begin
         hex_v = 4'(char_in[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_colon   = (char_in == hrl_pkg::COLON_CHAR);
   assign byte_val   = {nibble_ff, hex_v};
   assign byte_sum   = sum_ff + byte_val;
   assign addr_shift = {addr_ff[11:0], hex_v};
   assign digit_inc  = digit_ff + 2'd1;
   assign range_sum  = {1'b0, addr_shift} + {9'd0, left_ff};

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      nibble_in  = nibble_ff;
      left_in    = left_ff;
      addr_in    = addr_ff;
      sum_in     = sum_ff;
      kind_in    = kind_ff;
      start_rec  = 1'b0;
      has_result = 1'b0;
      result.kind      = hrl_pkg::RK_WRITE;
      result.address   = 16'd0;
      result.data      = 8'd0;
      result.type_code = kind_ff;

      case (phase_ff)
         hrl_pkg::PH_LEN, hrl_pkg::PH_ADDR, hrl_pkg::PH_TYPE,
         hrl_pkg::PH_DATA, hrl_pkg::PH_SUM: begin
            if (!hex_ok) begin
               has_result  = 1'b1;
               result.kind = hrl_pkg::RK_CHAR;
               phase_in    = hrl_pkg::PH_WAIT;
               start_rec   = is_colon;
            end else if (phase_ff == hrl_pkg::PH_ADDR) begin
               addr_in  = addr_shift;
               digit_in = digit_inc;
               if (digit_inc == 2'd0) begin
                  sum_in = sum_ff + addr_shift[7:0] + addr_shift[15:8];
                  if (range_sum > hrl_pkg::MEM_LIMIT) begin
                     has_result  = 1'b1;
                     result.kind = hrl_pkg::RK_RANGE;
                     phase_in    = hrl_pkg::PH_WAIT;
                  end else begin
                     phase_in = hrl_pkg::PH_TYPE;
                  end
               end
            end else if (digit_ff == 2'd0) begin
               nibble_in = hex_v;
               digit_in  = 2'd1;
            end else begin
               digit_in = 2'd0;
               sum_in   = byte_sum;
               case (phase_ff)
                  hrl_pkg::PH_LEN: begin
                     left_in  = byte_val;
                     phase_in = hrl_pkg::PH_ADDR;
                  end
                  hrl_pkg::PH_TYPE: begin
                     kind_in  = byte_val;
                     phase_in = (left_ff != 8'd0) ? hrl_pkg::PH_DATA : hrl_pkg::PH_SUM;
                  end
                  hrl_pkg::PH_DATA: begin
                     addr_in        = addr_ff + 16'd1;
                     left_in        = left_ff - 8'd1;
                     has_result     = 1'b1;
                     result.kind    = hrl_pkg::RK_WRITE;
                     result.address = addr_ff;
                     result.data    = byte_val;
                     if (left_ff == 8'd1) begin
                        phase_in = hrl_pkg::PH_SUM;
                     end
                  end
                  default: begin
                     has_result  = 1'b1;
                     result.kind = (byte_sum == 8'd0) ? hrl_pkg::RK_OK : hrl_pkg::RK_BAD;
                     phase_in    = hrl_pkg::PH_WAIT;
                  end
               endcase
            end
         end
         default: begin
            phase_in  = hrl_pkg::PH_WAIT;
            start_rec = is_colon;
         end
      endcase

      if (start_rec) begin
         phase_in  = hrl_pkg::PH_LEN;
         digit_in  = 2'd0;
         nibble_in = 4'd0;
         left_in   = 8'd0;
         addr_in   = 16'd0;
         sum_in    = 8'd0;
         kind_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrl_pkg::PH_WAIT;
         digit_ff  <= 2'd0;
         nibble_ff <= 4'd0;
         left_ff   <= 8'd0;
         addr_ff   <= 16'd0;
         sum_ff    <= 8'd0;
         kind_ff   <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         digit_ff  <= digit_in;
         nibble_ff <= nibble_in;
         left_ff   <= left_in;
         addr_ff   <= addr_in;
         sum_ff    <= sum_in;
         kind_ff   <= kind_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hrl_out_stage.sv */
// Result register holding one beat for the rsp_ channel.
// Depends on hrl_pkg.
`default_nettype none

module hrl_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire hrl_pkg::result_type load_data,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output hrl_pkg::result_type      rsp_data
);

   logic                valid_ff, valid_in;
   hrl_pkg::result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hex_record_loader.sv */
// Hex record loader top level: input register, record parser, result register.
// A character is held in the input register, and its result beat in the result register.
// Throughput: one character per cycle, limited by the single parser stage.
// A result beat stalls the parser only while the result register is full and not taken.
// Reset (synchronous, active high) empties both registers and waits for a colon.
// Depends on hrl_pkg, hrl_decode and hrl_out_stage.
`default_nettype none

module hex_record_loader (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_result_kind,
   output logic [15:0]      rsp_write_address,
   output logic [7:0]       rsp_write_byte,
   output logic [7:0]       rsp_type_code
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                step;
   logic                has_result;
   logic                out_free;
   hrl_pkg::result_type result;
   hrl_pkg::result_type rsp_data;

   assign step        = in_valid_ff && (!has_result || out_free);
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_in;
      end
   end

   hrl_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .char_in    (in_char_ff),
      .step       (step),
      .result     (result),
      .has_result (has_result)
   );

   hrl_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && has_result),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_kind   = rsp_data.kind;
   assign rsp_write_address = rsp_data.address;
   assign rsp_write_byte    = rsp_data.data;
   assign rsp_type_code     = rsp_data.type_code;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for hex_record_loader: a table of directed characters, then random records.
// Results are predicted per accepted character and checked beat by beat against the rsp_ channel.
// Depends on hrl_pkg and the hex_record_loader RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEMS_PER_PHASE = 340;
   localparam int CYCLE_LIMIT = 400_000;

   typedef enum logic [1:0] {
      EXP_PREDICT,
      EXP_NONE,
      EXP_LITERAL
   } exp_source_type;

   typedef struct packed {
      exp_source_type      src;
      hrl_pkg::result_type want;
   } item_tag_type;

   typedef struct packed {
      logic [7:0]          ch;
      exp_source_type      src;
      hrl_pkg::result_type want;
   } stim_row_type;

   localparam hrl_pkg::result_type NO_RESULT = '{hrl_pkg::RK_WRITE, 16'h0000, 8'h00, 8'h00};

   stim_row_type directed_rows [0:32] = '{
      '{8'h00, EXP_NONE, NO_RESULT},
      '{8'hFF, EXP_NONE, NO_RESULT},
      '{":", EXP_NONE, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"1", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_LITERAL, '{hrl_pkg::RK_RANGE, 16'h0000, 8'h00, 8'h00}},
      '{":", EXP_NONE, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"1", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"f", EXP_PREDICT, NO_RESULT},
      '{"f", EXP_PREDICT, NO_RESULT},
      '{"a", EXP_PREDICT, NO_RESULT},
      '{"5", EXP_LITERAL, '{hrl_pkg::RK_WRITE, 16'h0FFF, 8'hA5, 8'hFF}},
      '{"G", EXP_LITERAL, '{hrl_pkg::RK_CHAR, 16'h0000, 8'h00, 8'hFF}},
      '{":", EXP_NONE, NO_RESULT},
      '{":", EXP_LITERAL, '{hrl_pkg::RK_CHAR, 16'h0000, 8'h00, 8'h00}},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"0", EXP_PREDICT, NO_RESULT},
      '{"1", EXP_PREDICT, NO_RESULT},
      '{"F", EXP_PREDICT, NO_RESULT},
      '{"E", EXP_LITERAL, '{hrl_pkg::RK_BAD, 16'h0000, 8'h00, 8'h01}}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [15:0] rsp_write_address;
   logic [7:0]  rsp_write_byte;
   logic [7:0]  rsp_type_code;

   int send_idle_pct = 8;
   int rcv_idle_pct = 74;
   int fault_count = 0;
   int cycle_count = 0;

   item_tag_type        item_tags[$];
   hrl_pkg::result_type pending_results[$];

   // parser state as the loader should hold it
   hrl_pkg::phase_type rec_phase = hrl_pkg::PH_WAIT;
   logic [1:0] digit_no = '0;
   logic [3:0] hi_nib = '0;
   logic [7:0] bytes_due = '0;
   logic [15:0] next_addr = '0;
   logic [7:0] byte_sum = '0;
   logic [7:0] rec_type = '0;

   hex_record_loader uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_type_code     (rsp_type_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
      nib = '0;
      if (c >= "0" && c <= "9") begin
         nib = 4'(c - "0");
         return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
         nib = 4'(c - "A" + 10);
         return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
         nib = 4'(c - "a" + 10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void open_record();
      rec_phase = hrl_pkg::PH_LEN;
      digit_no = '0;
      hi_nib = '0;
      bytes_due = '0;
      next_addr = '0;
      byte_sum = '0;
      rec_type = '0;
   endfunction

   // returns 1 when the character gives a result beat
   function automatic bit decode_char(input logic [7:0] c, output hrl_pkg::result_type r);
      logic [3:0] nib;
      logic [7:0] b;
      r = NO_RESULT;
      if (rec_phase == hrl_pkg::PH_WAIT) begin
         if (c == hrl_pkg::COLON_CHAR) open_record();
         return 1'b0;
      end
      if (!hex_digit(c, nib)) begin
         r.kind = hrl_pkg::RK_CHAR;
         r.type_code = rec_type;
         rec_phase = hrl_pkg::PH_WAIT;
         if (c == hrl_pkg::COLON_CHAR) open_record();
         return 1'b1;
      end
      if (rec_phase == hrl_pkg::PH_ADDR) begin
         next_addr = {next_addr[11:0], nib};
         digit_no = digit_no + 2'd1;
         if (digit_no != 2'd0) return 1'b0;
         byte_sum = byte_sum + next_addr[7:0] + next_addr[15:8];
         if (int'(next_addr) + int'(bytes_due) > int'(hrl_pkg::MEM_DEPTH)) begin
            rec_phase = hrl_pkg::PH_WAIT;
            r.kind = hrl_pkg::RK_RANGE;
            r.type_code = rec_type;
            return 1'b1;
         end
         rec_phase = hrl_pkg::PH_TYPE;
         return 1'b0;
      end
      if (digit_no == 2'd0) begin
         hi_nib = nib;
         digit_no = 2'd1;
         return 1'b0;
      end
      digit_no = 2'd0;
      b = {hi_nib, nib};
      byte_sum = byte_sum + b;
      case (rec_phase)
         hrl_pkg::PH_LEN: begin
            bytes_due = b;
            rec_phase = hrl_pkg::PH_ADDR;
            return 1'b0;
         end
         hrl_pkg::PH_TYPE: begin
            rec_type = b;
            rec_phase = (bytes_due != 8'd0) ? hrl_pkg::PH_DATA : hrl_pkg::PH_SUM;
            return 1'b0;
         end
         hrl_pkg::PH_DATA: begin
            r = hrl_pkg::result_type'{hrl_pkg::RK_WRITE, next_addr, b, rec_type};
            next_addr = next_addr + 16'd1;
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'd0) rec_phase = hrl_pkg::PH_SUM;
            return 1'b1;
         end
         default: begin
            rec_phase = hrl_pkg::PH_WAIT;
            r.kind = (byte_sum == 8'd0) ? hrl_pkg::RK_OK : hrl_pkg::RK_BAD;
            r.type_code = rec_type;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'("0" + n);
      return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
   endfunction

   // receiver side: random stalls, checking on accepted beats and prediction on accepted characters
   always @(posedge clock) begin : rsp_side
      hrl_pkg::result_type predicted;
      hrl_pkg::result_type want;
      item_tag_type        tag;
      bit                  gives;
      bit                  wrong;
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat: kind %0d address %h byte %h type %h",
                        $time, rsp_result_kind, rsp_write_address, rsp_write_byte,
                        rsp_type_code);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               wrong = 1'b0;
               if (rsp_result_kind !== want.kind) begin
                  $display("%0t: result_kind expected %0d, got %0d",
                           $time, want.kind, rsp_result_kind);
                  wrong = 1'b1;
               end
               if (rsp_write_address !== want.address) begin
                  $display("%0t: write_address expected %h, got %h",
                           $time, want.address, rsp_write_address);
                  wrong = 1'b1;
               end
               if (rsp_write_byte !== want.data) begin
                  $display("%0t: write_byte expected %h, got %h",
                           $time, want.data, rsp_write_byte);
                  wrong = 1'b1;
               end
               if (rsp_type_code !== want.type_code) begin
                  $display("%0t: type_code expected %h, got %h",
                           $time, want.type_code, rsp_type_code);
                  wrong = 1'b1;
               end
               if (wrong) fault_count++;
            end
         end
         if (req_valid && req_ready) begin
            tag = item_tags.pop_front();
            gives = decode_char(req_char_in, predicted);
            if (tag.src == EXP_LITERAL) pending_results.push_back(tag.want);
            else if (tag.src == EXP_PREDICT && gives) pending_results.push_back(predicted);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input exp_source_type src,
                            input hrl_pkg::result_type want);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      item_tags.push_back(item_tag_type'{src, want});
      req_valid <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // one record, mostly well formed; some overrun memory, carry a bad checksum or a stray byte
   task automatic send_record(inout int items);
      logic [7:0]  rec_bytes[$];
      logic [7:0]  text[$];
      logic [7:0]  total;
      logic [7:0]  junk;
      logic [3:0]  nib;
      logic [15:0] addr;
      int          count;
      int          base;
      int          pos;
      repeat ($urandom_range(0, 3)) begin
         do junk = 8'($urandom_range(0, 255)); while (junk == hrl_pkg::COLON_CHAR);
         send_char(junk, EXP_PREDICT, NO_RESULT);
      end
      count = ($urandom_range(0, 31) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
      case ($urandom_range(0, 7))
         0: base = $urandom_range(0, 65535);
         1: base = int'(hrl_pkg::MEM_DEPTH) - count + int'($urandom_range(0, 1));
         default: base = $urandom_range(0, int'(hrl_pkg::MEM_DEPTH) - count);
      endcase
      addr = base[15:0];
      rec_bytes.push_back(8'(count));
      rec_bytes.push_back(addr[15:8]);
      rec_bytes.push_back(addr[7:0]);
      rec_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
      repeat (count) rec_bytes.push_back(8'($urandom_range(0, 255)));
      total = '0;
      foreach (rec_bytes[i]) total = total + rec_bytes[i];
      total = -total;
      if ($urandom_range(0, 7) == 0) total = total ^ 8'($urandom_range(1, 255));
      rec_bytes.push_back(total);
      text.push_back(hrl_pkg::COLON_CHAR);
      foreach (rec_bytes[i]) begin
         text.push_back(hex_char(rec_bytes[i][7:4]));
         text.push_back(hex_char(rec_bytes[i][3:0]));
      end
      if ($urandom_range(0, 9) == 0) begin
         pos = $urandom_range(1, text.size() - 1);
         do junk = 8'($urandom_range(0, 255)); while (hex_digit(junk, nib));
         text[pos] = junk;
      end
      foreach (text[i]) send_char(text[i], EXP_PREDICT, NO_RESULT);
      items += text.size();
   endtask

   initial begin : stimulus
      int items;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].src, directed_rows[i].want);
      for (int ph = 0; ph < 3; ph++) begin
         drain();
         send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 74 : 0;
         rcv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 8 : 0;
         items = 0;
         while (items < ITEMS_PER_PHASE) send_record(items);
      end
      drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
